### design/cbq_pkg.sv
// Shared types, widths, register indexes and reset values for the cascaded biquad notch.
package cbq_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int COEF_W    = 18;
  localparam int SHIFT_W   = 4;
  localparam int OUT_W     = 40;
  localparam int ACC_W     = 64;
  localparam int CFG_IDX_W = 3;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [COEF_W-1:0]   coef_t;
  typedef logic [SHIFT_W-1:0]         shift_t;
  typedef logic signed [OUT_W-1:0]    out_t;
  typedef logic [CFG_IDX_W-1:0]       cfg_idx_t;

  localparam cfg_idx_t REG_S1_B1   = 3'd0;
  localparam cfg_idx_t REG_S1_NA1  = 3'd1;
  localparam cfg_idx_t REG_S1_NA2  = 3'd2;
  localparam cfg_idx_t REG_S2_B1   = 3'd3;
  localparam cfg_idx_t REG_S2_NA1  = 3'd4;
  localparam cfg_idx_t REG_S2_NA2  = 3'd5;
  localparam cfg_idx_t REG_SHIFT   = 3'd6;

  localparam coef_t  RST_S1_B1   = -18'sd128356;
  localparam coef_t  RST_S1_NA1  = 18'sd127922;
  localparam coef_t  RST_S1_NA2  = -18'sd62632;
  localparam coef_t  RST_S2_B1   = -18'sd115996;
  localparam coef_t  RST_S2_NA1  = 18'sd123486;
  localparam coef_t  RST_S2_NA2  = -18'sd58208;
  localparam shift_t RST_SHIFT   = 4'd6;

endpackage

### design/cbq_ifs.sv
// Valid/ready channel interfaces for the sample input and the filtered result output.
interface cbq_in_if
  import cbq_pkg::*;
();
  logic    valid;
  logic    ready;
  sample_t sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

interface cbq_out_if
  import cbq_pkg::*;
();
  logic valid;
  logic ready;
  out_t stage1_out;
  out_t stage2_out;
  logic stage1_overflow;
  logic stage2_overflow;

  modport source (output valid, output stage1_out, output stage2_out,
                  output stage1_overflow, output stage2_overflow, input ready);
  modport sink (input valid, input stage1_out, input stage2_out,
                input stage1_overflow, input stage2_overflow, output ready);
endinterface

### design/cascaded_biquad_notch.sv
// Two cascaded fixed-point biquad sections sharing one multiplier under a small sequencer.
//
//   channel   modport  payload                                         
//   samples   sink     sample                                           
//   results   source   stage1_out, stage2_out, stage1/2_overflow        
//   cfg_*     write    cfg_index selects register, cfg_data is the value
//
// A transaction on samples runs through the accepting cycle, then for each section the
// multiply-accumulate steps of the shared 18 by (STATE_WIDTH-STATE_WIDTH/2+1) multiplier
// and adder (three products, each split into two partial products) and a final step to
// round and store; no new sample is accepted before the second section's final step ends.
// Synchronous reset restores the coefficients and the shift and clears all filter history.
// A new sample is accepted while the previous result still waits; the second section's
// final cycle holds until the output register is free.
module cascaded_biquad_notch
  import cbq_pkg::*;
#(
  parameter int COEF_FRAC_BITS = 16,
  parameter int CHECK_WIDTH    = 21,
  parameter int STATE_WIDTH    = 40
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  cfg_idx_t      cfg_index,
  input  coef_t         cfg_data,
  cbq_in_if.sink        samples,
  cbq_out_if.source     results
);

  localparam int SW     = STATE_WIDTH;
  localparam int LO_W   = SW / 2;
  localparam int HI_W   = SW - LO_W;
  localparam int OP_W   = HI_W + 1;
  localparam int PROD_W = COEF_W + OP_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MAC  = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  localparam logic [2:0] STEP_LAST = 3'd6;

  logic [1:0]  state;
  logic        sec;
  logic [2:0]  step;
  logic [ACC_W-1:0] acc;
  logic signed [PROD_W-1:0] prod;
  logic        prod_hi;
  logic [SW-1:0] xin;

  coef_t  s1_b1, s1_na1, s1_na2, s2_b1, s2_na1, s2_na2;
  shift_t shift;

  sample_t       s1_x1, s1_x2;
  logic [SW-1:0] s1_y1, s1_y2, s2_x1, s2_x2, s2_y1, s2_y2;

  logic [SW-1:0] y1_hold;
  logic          ovf1_hold;

  logic out_valid;
  out_t out_s1, out_s2;
  logic out_o1, out_o2;

  coef_t             coef_sel;
  logic [SW-1:0]     op_val;
  logic signed [OP_W-1:0] op_part;
  logic [ACC_W-1:0]  prod_ext;
  logic [ACC_W-1:0]  addend;
  logic [ACC_W-1:0]  init_val;
  logic [SW:0]       x_sum;
  logic [SW-1:0]     x1_sel, x2_sel, y1_sel, y2_sel;
  logic [ACC_W-1:0]  acc_rnd;
  logic [ACC_W-1:0]  r64;
  logic [SW-1:0]     y_new;
  logic              ovf_new;
  logic [ACC_W-1:0]  y64;
  logic [ACC_W-1:0]  y1_64;
  logic [SW:0]       ish_sum;
  logic [SW:0]       ish_shr;
  logic              out_free;
  logic              fin_last;

  always_comb begin
    x1_sel = sec ? s2_x1 : SW'($signed(s1_x1));
    x2_sel = sec ? s2_x2 : SW'($signed(s1_x2));
    y1_sel = sec ? s2_y1 : s1_y1;
    y2_sel = sec ? s2_y2 : s1_y2;

    case ({sec, step[2:1]})
      3'b000:  coef_sel = s1_b1;
      3'b001:  coef_sel = s1_na1;
      3'b010:  coef_sel = s1_na2;
      3'b100:  coef_sel = s2_b1;
      3'b101:  coef_sel = s2_na1;
      3'b110:  coef_sel = s2_na2;
      default: coef_sel = '0;
    endcase

    case (step[2:1])
      2'd0:    op_val = x1_sel;
      2'd1:    op_val = y1_sel;
      2'd2:    op_val = y2_sel;
      default: op_val = '0;
    endcase

    if (step[0]) begin
      op_part = {op_val[SW-1], op_val[SW-1:LO_W]};
    end else begin
      op_part = {{(OP_W-LO_W){1'b0}}, op_val[LO_W-1:0]};
    end

    prod_ext = {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};
    addend   = prod_hi ? (prod_ext << LO_W) : prod_ext;

    x_sum    = {xin[SW-1], xin} + {x2_sel[SW-1], x2_sel};
    init_val = {{(ACC_W-SW-1){x_sum[SW]}}, x_sum} << COEF_FRAC_BITS;

    acc_rnd  = acc + (ACC_W'(1) << (COEF_FRAC_BITS - 1));
    r64      = ACC_W'($signed(acc_rnd) >>> COEF_FRAC_BITS);
    y_new    = r64[SW-1:0];
    ovf_new  = !((&r64[ACC_W-1:CHECK_WIDTH-1]) || !(|r64[ACC_W-1:CHECK_WIDTH-1]));
    y64      = {{(ACC_W-SW){y_new[SW-1]}}, y_new};
    y1_64    = {{(ACC_W-SW){y1_hold[SW-1]}}, y1_hold};

    ish_sum  = {y_new[SW-1], y_new} + ((((SW+1)'(1)) << shift) >> 1);
    ish_shr  = (SW+1)'($signed(ish_sum) >>> shift);

    out_free = !out_valid || results.ready;
    fin_last = (state == S_FIN) && sec && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      sec       <= 1'b0;
      step      <= '0;
      out_valid <= 1'b0;
      s1_b1     <= RST_S1_B1;
      s1_na1    <= RST_S1_NA1;
      s1_na2    <= RST_S1_NA2;
      s2_b1     <= RST_S2_B1;
      s2_na1    <= RST_S2_NA1;
      s2_na2    <= RST_S2_NA2;
      shift     <= RST_SHIFT;
      s1_x1     <= '0;
      s1_x2     <= '0;
      s1_y1     <= '0;
      s1_y2     <= '0;
      s2_x1     <= '0;
      s2_x2     <= '0;
      s2_y1     <= '0;
      s2_y2     <= '0;
    end else begin
      if (fin_last) begin
        out_valid <= 1'b1;
      end else if (results.valid && results.ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          REG_S1_B1:  s1_b1  <= cfg_data;
          REG_S1_NA1: s1_na1 <= cfg_data;
          REG_S1_NA2: s1_na2 <= cfg_data;
          REG_S2_B1:  s2_b1  <= cfg_data;
          REG_S2_NA1: s2_na1 <= cfg_data;
          REG_S2_NA2: s2_na2 <= cfg_data;
          REG_SHIFT:  shift  <= cfg_data[SHIFT_W-1:0];
          default: ;
        endcase
      end
      unique case (state)
        S_IDLE: begin
          if (samples.valid) begin
            xin   <= SW'($signed(samples.sample));
            sec   <= 1'b0;
            step  <= '0;
            state <= S_MAC;
          end
        end
        S_MAC: begin
          if (step != STEP_LAST) begin
            prod    <= coef_sel * op_part;
            prod_hi <= step[0];
          end
          if (step == '0) begin
            acc <= init_val;
          end else begin
            acc <= acc + addend;
          end
          if (step == STEP_LAST) begin
            state <= S_FIN;
          end else begin
            step <= step + 3'd1;
          end
        end
        S_FIN: begin
          if (!sec) begin
            s1_x2     <= s1_x1;
            s1_x1     <= xin[SAMPLE_W-1:0];
            s1_y2     <= s1_y1;
            s1_y1     <= y_new;
            y1_hold   <= y_new;
            ovf1_hold <= ovf_new;
            xin       <= ish_shr[SW-1:0];
            sec       <= 1'b1;
            step      <= '0;
            state     <= S_MAC;
          end else if (out_free) begin
            s2_x2     <= s2_x1;
            s2_x1     <= xin;
            s2_y2     <= s2_y1;
            s2_y1     <= y_new;
            out_s1    <= y1_64[OUT_W-1:0];
            out_s2    <= y64[OUT_W-1:0];
            out_o1    <= ovf1_hold;
            out_o2    <= ovf_new;
            sec       <= 1'b0;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign samples.ready           = (state == S_IDLE);
  assign results.valid           = out_valid;
  assign results.stage1_out      = out_s1;
  assign results.stage2_out      = out_s2;
  assign results.stage1_overflow = out_o1;
  assign results.stage2_overflow = out_o2;

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    samples.valid && samples.ready |=> state == S_MAC && step == '0 && !sec)
    else $error("accepted sample did not start section one");

  a_result_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(results.valid) |-> $past(state == S_FIN && sec))
    else $error("result raised outside the last section's final cycle");

  a_step_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_MAC |-> step <= STEP_LAST)
    else $error("sequencer step out of range");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    results.valid && !results.ready |=> results.valid)
    else $error("pending result dropped");

endmodule
